// File: rtl/gdn_pkg.sv
package gdn_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int OUT_FRAC_BITS = 16;
    localparam int EXP_FRAC_BITS = 8;

    localparam int IN_W   = 16;
    localparam int FS_W   = 16;
    localparam int OUT_W  = OUT_FRAC_BITS + 1;
    localparam int G_W    = EXP_FRAC_BITS + 4;
    localparam int CFG_W  = 16;

    localparam int LOG_FRAC = 30;
    localparam int N_W      = 4;
    localparam int L_W      = LOG_FRAC + N_W;
    localparam int P_W      = L_W + G_W - EXP_FRAC_BITS;
    localparam int K_W      = P_W - LOG_FRAC;
    localparam int S_W      = K_W + 1;

    // normalize + squaring steps, diff, product, root steps, output
    localparam int LOG_LAT  = LOG_FRAC + 1;
    localparam int PIPE_LAT = LOG_LAT + 2 + LOG_FRAC + 1;

    localparam int GAMMA_RESET_INT = ((22 << EXP_FRAC_BITS) / 10)
        + ((((22 << EXP_FRAC_BITS) % 10) >= 5) ? 1 : 0);
    localparam logic [G_W-1:0]  GAMMA_RESET = G_W'(GAMMA_RESET_INT);
    localparam logic [FS_W-1:0] FS_RESET    = FS_W'(255);

    typedef enum logic [0:0] {
        REG_GAMMA      = 1'b0,
        REG_FULL_SCALE = 1'b1
    } cfg_reg_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int t = 0; t < 32; t++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q.32 value of 2^(-2^-i)
    function automatic logic [31:0] root_c(input int i);
        logic [63:0] c;
        c = isqrt64(64'd1 << 63);
        for (int j = 2; j <= LOG_FRAC; j++) begin
            if (j <= i) begin
                c = isqrt64(c << 32);
            end
        end
        return c[31:0];
    endfunction

endpackage

// File: rtl/gdn_log2.sv
module gdn_log2 (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [gdn_pkg::FS_W-1:0] v,
    output logic [gdn_pkg::L_W-1:0]  l_out
);
    import gdn_pkg::*;

    logic [31:0]         m_reg    [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] frac_reg [0:LOG_FRAC];
    logic [N_W-1:0]      n_reg    [0:LOG_FRAC];

    logic [N_W-1:0] n_next;
    logic [31:0]    m_next;

    always_comb begin
        n_next = '0;
        for (int i = 0; i < FS_W; i++) begin
            if (v[i]) begin
                n_next = N_W'(i);
            end
        end
        m_next = {{(32-FS_W){1'b0}}, v} << (5'd31 - 5'(n_next));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= m_next;
            frac_reg[0] <= '0;
            n_reg[0]    <= n_next;
        end
    end

    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_sq
        logic [63:0] prod;
        logic        hi;
        assign prod = {32'd0, m_reg[j]} * {32'd0, m_reg[j]};
        assign hi   = prod[63];
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[j+1]    <= hi ? prod[63:32] : prod[62:31];
                frac_reg[j+1] <= {frac_reg[j][LOG_FRAC-2:0], hi};
                n_reg[j+1]    <= n_reg[j];
            end
        end
    end

    assign l_out = {n_reg[LOG_FRAC], frac_reg[LOG_FRAC]};

endmodule

// File: rtl/gdn_pow2.sv
module gdn_pow2 (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [gdn_pkg::P_W-1:0]   p,
    input  logic                      zero_in,
    input  logic                      sat_in,
    output logic [gdn_pkg::OUT_W-1:0] r_out
);
    import gdn_pkg::*;

    localparam logic [63:0] ONE = 64'd1 << OUT_FRAC_BITS;

    logic [32:0]         y_reg [0:LOG_FRAC-1];
    logic [LOG_FRAC-1:0] f_reg [0:LOG_FRAC-1];
    logic [K_W-1:0]      k_reg [0:LOG_FRAC-1];
    logic [OUT_W-1:0]    r_reg;

    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_root
        localparam logic [31:0] CJ = root_c(j + 1);
        logic [32:0]         y_prev;
        logic [LOG_FRAC-1:0] f_prev;
        logic [K_W-1:0]      k_prev;
        logic [64:0]         prod;
        if (j == 0) begin : g_first
            assign y_prev = 33'd1 << 32;
            assign f_prev = p[LOG_FRAC-1:0];
            assign k_prev = p[P_W-1:LOG_FRAC];
        end else begin : g_rest
            assign y_prev = y_reg[j-1];
            assign f_prev = f_reg[j-1];
            assign k_prev = k_reg[j-1];
        end
        assign prod = {32'd0, y_prev} * {33'd0, CJ};
        always_ff @(posedge aclk) begin
            if (en) begin
                y_reg[j] <= f_prev[LOG_FRAC-1-j] ? prod[64:32] : y_prev;
                f_reg[j] <= f_prev;
                k_reg[j] <= k_prev;
            end
        end
    end

    logic [S_W-1:0]   s;
    logic [63:0]      sum;
    logic [63:0]      r;
    logic [OUT_W-1:0] r_next;

    always_comb begin
        s      = S_W'(k_reg[LOG_FRAC-1]) + S_W'(32 - OUT_FRAC_BITS);
        sum    = 64'(y_reg[LOG_FRAC-1]) + (64'd1 << (s - S_W'(1)));
        r      = sum >> s;
        r_next = '0;
        if (zero_in) begin
            r_next = '0;
        end else if (sat_in) begin
            r_next = OUT_W'(ONE);
        end else if (s >= S_W'(64)) begin
            r_next = '0;
        end else if (r > ONE) begin
            r_next = OUT_W'(ONE);
        end else begin
            r_next = r[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
        end
    end

    assign r_out = r_reg;

endmodule

// File: rtl/gdn_channel.sv
module gdn_channel (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [gdn_pkg::IN_W-1:0]  x_in,
    input  logic [gdn_pkg::FS_W-1:0]  full_scale,
    input  logic [gdn_pkg::G_W-1:0]   gamma,
    input  logic [gdn_pkg::L_W-1:0]   l_fs,
    output logic [gdn_pkg::OUT_W-1:0] r_out
);
    import gdn_pkg::*;

    localparam int FLAG_LAT = PIPE_LAT - 1;

    logic [SAMPLE_BITS-1:0] x;
    logic [FS_W-1:0]        xw;
    logic [L_W-1:0]         l_x;
    logic [L_W-1:0]         d_reg;
    logic [P_W-1:0]         p_reg;
    logic [L_W+G_W-1:0]     prod;
    logic                   zero_reg [0:FLAG_LAT-1];
    logic                   sat_reg  [0:FLAG_LAT-1];

    assign x  = x_in[SAMPLE_BITS-1:0];
    assign xw = FS_W'(x);

    gdn_log2 u_log (
        .aclk  (aclk),
        .en    (en),
        .v     (xw),
        .l_out (l_x)
    );

    assign prod = (L_W+G_W)'(d_reg) * (L_W+G_W)'(gamma);

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg       <= l_fs - l_x;
            p_reg       <= prod[L_W+G_W-1:EXP_FRAC_BITS];
            zero_reg[0] <= (xw == '0);
            sat_reg[0]  <= (xw >= full_scale);
            for (int i = 1; i < FLAG_LAT; i++) begin
                zero_reg[i] <= zero_reg[i-1];
                sat_reg[i]  <= sat_reg[i-1];
            end
        end
    end

    gdn_pow2 u_pow (
        .aclk    (aclk),
        .en      (en),
        .p       (p_reg),
        .zero_in (zero_reg[FLAG_LAT-1]),
        .sat_in  (sat_reg[FLAG_LAT-1]),
        .r_out   (r_out)
    );

endmodule

// File: rtl/gamma_decode_normalize_unit.sv
// Gamma decode of RGB pixels: each sample is divided by full_scale, raised to
// the power gamma_exponent (8 fraction bits) and returned as a 16-bit fraction
// saturated to 1.0. One pixel is taken every clock but for stalls; a pixel
// passes normalize, the 30 log2 squaring steps, diff, product, the 30 root
// multiplies (one per stage) and output. The whole pipeline holds while
// a result waits on m_ready. Write registers only with no pixel in flight.
module gamma_decode_normalize_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [gdn_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [gdn_pkg::IN_W-1:0]    s_red_in,
    input  logic [gdn_pkg::IN_W-1:0]    s_green_in,
    input  logic [gdn_pkg::IN_W-1:0]    s_blue_in,
    input  logic                        s_last_pixel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [gdn_pkg::OUT_W-1:0]   m_red_out,
    output logic [gdn_pkg::OUT_W-1:0]   m_green_out,
    output logic [gdn_pkg::OUT_W-1:0]   m_blue_out,
    output logic                        m_last_out
);
    import gdn_pkg::*;

    logic [G_W-1:0]  gamma_reg;
    logic [FS_W-1:0] fs_reg;
    logic            valid_reg [0:PIPE_LAT-1];
    logic            last_reg  [0:PIPE_LAT-1];
    logic            en;
    logic [L_W-1:0]  l_fs;

    assign en      = !valid_reg[PIPE_LAT-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= GAMMA_RESET;
            fs_reg    <= FS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAMMA:      gamma_reg <= cfg_data[G_W-1:0];
                REG_FULL_SCALE: fs_reg    <= cfg_data[FS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg[0] <= s_last_pixel;
            for (int i = 1; i < PIPE_LAT; i++) begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    gdn_log2 u_log_fs (
        .aclk  (aclk),
        .en    (en),
        .v     (fs_reg),
        .l_out (l_fs)
    );

    gdn_channel u_red (
        .aclk       (aclk),
        .en         (en),
        .x_in       (s_red_in),
        .full_scale (fs_reg),
        .gamma      (gamma_reg),
        .l_fs       (l_fs),
        .r_out      (m_red_out)
    );

    gdn_channel u_green (
        .aclk       (aclk),
        .en         (en),
        .x_in       (s_green_in),
        .full_scale (fs_reg),
        .gamma      (gamma_reg),
        .l_fs       (l_fs),
        .r_out      (m_green_out)
    );

    gdn_channel u_blue (
        .aclk       (aclk),
        .en         (en),
        .x_in       (s_blue_in),
        .full_scale (fs_reg),
        .gamma      (gamma_reg),
        .l_fs       (l_fs),
        .r_out      (m_blue_out)
    );

    assign m_valid    = valid_reg[PIPE_LAT-1];
    assign m_last_out = last_reg[PIPE_LAT-1];

endmodule

// File: rtl/gdn_checker.sv
module gdn_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [gdn_pkg::OUT_W-1:0] m_red_out,
    input logic [gdn_pkg::OUT_W-1:0] m_green_out,
    input logic [gdn_pkg::OUT_W-1:0] m_blue_out,
    input logic                      m_last_out
);
    import gdn_pkg::*;

    localparam logic [OUT_W-1:0] ONE = OUT_W'(1) << OUT_FRAC_BITS;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out)
            && $stable(m_green_out) && $stable(m_blue_out) && $stable(m_last_out))
        else $error("stalled transaction changed");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red_out <= ONE) && (m_green_out <= ONE) && (m_blue_out <= ONE))
        else $error("decoded fraction above 1.0");

endmodule

bind gamma_decode_normalize_unit gdn_checker u_gdn_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_red_out   (m_red_out),
    .m_green_out (m_green_out),
    .m_blue_out  (m_blue_out),
    .m_last_out  (m_last_out)
);

// File: tb/sv/tb_gamma_decode_normalize_unit.sv
`timescale 1ns / 100ps

module tb_gamma_decode_normalize_unit;
    import gdn_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = PIPE_LAT + 16;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
        logic             last;
    } pixel_out_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [0:0]          cfg_index = REG_GAMMA;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [IN_W-1:0]     s_red_in = '0;
    logic [IN_W-1:0]     s_green_in = '0;
    logic [IN_W-1:0]     s_blue_in = '0;
    logic                s_last_pixel = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [OUT_W-1:0]    m_red_out;
    logic [OUT_W-1:0]    m_green_out;
    logic [OUT_W-1:0]    m_blue_out;
    logic                m_last_out;

    logic [G_W-1:0]      gamma_q8;
    logic [FS_W-1:0]     full_scale;
    logic [63:0]         roots [1:LOG_FRAC];
    pixel_out_t          expected_pixels [$];
    int                  errors = 0;
    int                  cycle_count = 0;
    bit                  idle_en = 1'b1;
    int                  hold = 0;

    gamma_decode_normalize_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .s_last_pixel(s_last_pixel),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out),
        .m_last_out(m_last_out)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem, res, bt;
        rem = v;
        res = '0;
        bt  = 64'd1 << 62;
        while (bt > rem) bt = bt >> 2;
        while (bt != 0) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_q30(input logic [31:0] v);
        int n;
        logic [63:0] m, frac;
        n = 31;
        frac = '0;
        while (n > 0 && v[n] == 1'b0) n--;
        m = 64'(v) << (31 - n);
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(n) << LOG_FRAC) | frac;
    endfunction

    function automatic logic [OUT_W-1:0] decode_sample(input logic [15:0] x);
        logic [63:0] d, p, f, y, k, s, r;
        if (x == 0) return '0;
        if (32'(x) >= 32'(full_scale)) return OUT_W'(1 << OUT_FRAC_BITS);
        d = log2_q30(32'(full_scale)) - log2_q30(32'(x));
        p = (d * 64'(gamma_q8)) >> EXP_FRAC_BITS;
        k = p >> LOG_FRAC;
        f = p & ((64'd1 << LOG_FRAC) - 1);
        y = 64'd1 << 32;
        for (int b = LOG_FRAC - 1; b >= 0; b--) begin
            if (f[b]) y = (y * roots[LOG_FRAC - b]) >> 32;
        end
        s = k + 32 - OUT_FRAC_BITS;
        if (s >= 64) return '0;
        r = (y + (64'd1 << (s - 1))) >> s;
        if (r > (64'd1 << OUT_FRAC_BITS)) r = 64'd1 << OUT_FRAC_BITS;
        return r[OUT_W-1:0];
    endfunction

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** gamma_decode_normalize_unit: FAILED **");
            $finish;
        end
    end

    // result side: random stall after each transaction while idle_en is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold = 0;
        end else if (m_valid && m_ready) begin
            hold = idle_en ? $urandom_range(0, 13) : 0;
            m_ready <= (hold == 0);
        end else if (hold > 0) begin
            hold--;
            m_ready <= (hold == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pixel_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = expected_pixels.pop_front();
                if (m_red_out !== e.red) begin
                    $error("red_out exp %0d got %0d", e.red, m_red_out); errors++;
                end
                if (m_green_out !== e.green) begin
                    $error("green_out exp %0d got %0d", e.green, m_green_out); errors++;
                end
                if (m_blue_out !== e.blue) begin
                    $error("blue_out exp %0d got %0d", e.blue, m_blue_out); errors++;
                end
                if (m_last_out !== e.last) begin
                    $error("last_out exp %0d got %0d", e.last, m_last_out); errors++;
                end
            end
        end
    end

    task automatic drain();
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_GAMMA) gamma_q8 = data[G_W-1:0];
        else full_scale = data[FS_W-1:0];
    endtask

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic l);
        int gap;
        pixel_out_t e;
        gap = idle_en ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red_in <= r;
        s_green_in <= g;
        s_blue_in <= b;
        s_last_pixel <= l;
        do @(posedge aclk); while (!s_ready);
        e.red = decode_sample(r);
        e.green = decode_sample(g);
        e.blue = decode_sample(b);
        e.last = l;
        expected_pixels.push_back(e);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 3));
            1: return 16'($urandom_range(0, 32'(full_scale) + 2));
            2: return full_scale;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_default_config();
        send_pixel(16'd0, 16'd255, 16'd65535, 1'b0);
        send_pixel(16'd1, 16'd128, 16'd254, 1'b1);
        send_pixel(16'd256, 16'd2, 16'd64, 1'b0);
        stop_sending();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_GAMMA, CFG_W'(256));
        write_reg(REG_FULL_SCALE, 16'hFFFF);
        send_pixel(16'd1, 16'hFFFF, 16'h8000, 1'b1);
        send_pixel(16'h5555, 16'hAAAA, 16'hFFFE, 1'b0);
        stop_sending();
        write_reg(REG_GAMMA, CFG_W'(2048));
        send_pixel(16'd1, 16'h7FFF, 16'hFFFE, 1'b0);
        send_pixel(16'd60000, 16'd0, 16'd30000, 1'b1);
        stop_sending();
        write_reg(REG_FULL_SCALE, 16'd1);
        send_pixel(16'd0, 16'd1, 16'd2, 1'b0);
        stop_sending();
        // zero full scale behaves like one
        write_reg(REG_FULL_SCALE, 16'd0);
        send_pixel(16'd0, 16'd1, 16'hFFFF, 1'b1);
        stop_sending();
        // zero exponent and all-ones data beyond the register width
        write_reg(REG_FULL_SCALE, 16'd1000);
        write_reg(REG_GAMMA, CFG_W'(0));
        send_pixel(16'd0, 16'd1, 16'd999, 1'b0);
        stop_sending();
        write_reg(REG_GAMMA, 16'hFFFF);
        send_pixel(16'd1, 16'd500, 16'd999, 1'b1);
        send_pixel(16'd3, 16'd100, 16'd998, 1'b0);
        stop_sending();
        write_reg(REG_GAMMA, CFG_W'(100));
        send_pixel(16'd1, 16'd10, 16'd700, 1'b0);
        stop_sending();
    endtask

    task automatic test_random_streams();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_reg(REG_FULL_SCALE, 16'd255);
                1: write_reg(REG_FULL_SCALE, 16'hFFFF);
                2: write_reg(REG_FULL_SCALE, 16'd1023);
                default: write_reg(REG_FULL_SCALE, 16'($urandom_range(1, 65535)));
            endcase
            case (ph)
                0: write_reg(REG_GAMMA, CFG_W'(563));
                1: write_reg(REG_GAMMA, CFG_W'(2048));
                2: write_reg(REG_GAMMA, CFG_W'(256));
                default: write_reg(REG_GAMMA, CFG_W'($urandom_range(256, 2048)));
            endcase
            idle_en = (ph != 3);
            for (int i = 0; i < 200; i++) begin
                send_pixel(pick_sample(), pick_sample(), pick_sample(), 1'($urandom));
                if (ph == 5 && i == 100) begin
                    stop_sending();
                    while (expected_pixels.size() != 0) @(posedge aclk);
                end
            end
            stop_sending();
            idle_en = 1'b1;
        end
    endtask

    initial begin
        gamma_q8 = GAMMA_RESET;
        full_scale = FS_RESET;
        roots[1] = floor_sqrt(64'd1 << 63);
        for (int i = 2; i <= LOG_FRAC; i++) roots[i] = floor_sqrt(roots[i - 1] << 32);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_config();
        test_register_extremes();
        test_random_streams();
        drain();
        if (errors == 0) begin
            $display("** gamma_decode_normalize_unit: PASSED **");
        end else begin
            $display("** gamma_decode_normalize_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/gdn_pkg.sv
rtl/gdn_log2.sv
rtl/gdn_pow2.sv
rtl/gdn_channel.sv
rtl/gamma_decode_normalize_unit.sv
rtl/gdn_checker.sv
tb/sv/tb_gamma_decode_normalize_unit.sv
